// ----- hw/rtl/tcn_pkg.sv -----
// shared types, constants and functions of the two-compartment neuron step core
package tcn_pkg;

  localparam int unsigned POT_W      = 32;
  localparam int unsigned TGT_W      = 25;
  localparam int unsigned AW         = ((POT_W > TGT_W) ? POT_W : TGT_W) + 1;
  localparam int unsigned BW         = 17;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned NDIG       = (BW + DIG_W - 1) / DIG_W;
  localparam int unsigned BEXT       = NDIG * DIG_W;
  localparam int unsigned PRW        = AW + BW;
  localparam int unsigned DCNT_W     = $clog2(NDIG);
  localparam int unsigned SIG_DEPTH  = 256;
  localparam int unsigned SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

  localparam logic [CFG_IDX_W-1:0] CFG_BASAL_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APICAL_W  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOMA_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] a;
    logic signed [BW-1:0] b;
  } mul_req_t;

  typedef logic [15:0] sig_table_t [SIG_DEPTH];

  // clamp a wide value to the signed potential range
  function automatic logic signed [POT_W-1:0] sat_pot(input logic signed [PRW-1:0] v);
    logic signed [PRW-1:0] maxv;
    logic signed [PRW-1:0] minv;
    maxv = PRW'(signed'({1'b0, {(POT_W-1){1'b1}}}));
    minv = -maxv - PRW'(1);
    if (v > maxv) begin
      return POT_W'(maxv);
    end else if (v < minv) begin
      return POT_W'(minv);
    end
    return POT_W'(v);
  endfunction

  // unsigned quotient by restoring shift and subtract
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid of a q4.12 value as unsigned q0.16, series expansion of exp
  function automatic logic [15:0] sigmoid_q16(input longint x);
    longint unsigned t;
    longint unsigned f;
    longint unsigned n;
    longint unsigned e;
    longint unsigned term;
    longint unsigned den;
    longint unsigned s;
    t = (x < 0) ? longint'(-x) : longint'(x);
    f = t & 64'hFFF;
    n = t >> 12;
    e = 64'd1 << 30;
    term = 64'd1 << 30;
    for (longint unsigned k = 1; k <= 12; k++) begin
      term = udiv64(term * f, k * 64'd4096);
      if (k[0]) e = e - term;
      else e = e + term;
    end
    for (longint unsigned k = 0; k < n; k++) begin
      e = (e * EXP_M1_Q30) >> 30;
    end
    den = (64'd1 << 30) + e;
    s = udiv64((64'd1 << 46) + (den >> 1), den);
    if (x < 0) s = 64'd65536 - s;
    return s[15:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tab;
    longint mid;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      mid = longint'((longint'(2 * i + 1) * 65536) / (2 * SIG_DEPTH)) - 32768;
      tab[i] = sigmoid_q16(mid);
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ----- hw/rtl/two_compartment_neuron_step_core.sv -----
// two-compartment leaky integrate-and-fire neuron, one time step per transaction
// each input transaction is worked through as 11 products
//   (issue, five radix-16 digits, done) on the shared multiplier, then a finish state
// the input stalls until the step is through the single digit-serial multiplier
// a finished result waits in the output register while the next step is taken in
// reset: potentials, spike flag and spike time clear; registers take their documented values
module two_compartment_neuron_step_core import tcn_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          basal_input_i,
  input  logic signed [15:0]          apical_input_i,
  input  logic signed [15:0]          recurrent_input_i,
  input  logic [31:0]                 time_stamp_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        spike_o,
  output logic [31:0]                 last_spike_time_o,
  output logic signed [31:0]          soma_level_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // product steps, in order
  localparam logic [3:0] SP_BASAL_FF  = 4'd0;
  localparam logic [3:0] SP_BASAL_REC = 4'd1;
  localparam logic [3:0] SP_BASAL_LK  = 4'd2;
  localparam logic [3:0] SP_APIC_FF   = 4'd3;
  localparam logic [3:0] SP_APIC_REC  = 4'd4;
  localparam logic [3:0] SP_APIC_LK   = 4'd5;
  localparam logic [3:0] SP_SIG_ARG   = 4'd6;
  localparam logic [3:0] SP_COUPLE    = 4'd7;
  localparam logic [3:0] SP_DIRECT    = 4'd8;
  localparam logic [3:0] SP_GATE      = 4'd9;
  localparam logic [3:0] SP_SOMA_LK   = 4'd10;

  // configuration registers
  logic [31:0] bw_q, aw_q;
  logic [15:0] sw_q, ratio_q, slope_q;
  logic [47:0] leak_q;
  logic [31:0] thr_q;

  // neuron state
  logic signed [POT_W-1:0] pb_q, pb_d, pa_q, pa_d, ps_q, ps_d;
  logic                    spike_q, spike_d;
  logic [31:0]             tstore_q, tstore_d;

  // latched input transaction and working registers
  logic signed [15:0]      bin_q, ain_q, rec_q;
  logic [31:0]             stamp_q;
  logic signed [PRW-1:0]   sum_q, sum_d;
  logic signed [AW-1:0]    diff_q, diff_d;
  logic [15:0]             gate_q, gate_d;

  logic [1:0] state_q;
  logic [3:0] step_q;

  // output register
  logic                    out_valid_q;
  logic                    out_spike_q;
  logic [31:0]             out_time_q;
  logic signed [31:0]      out_soma_q;

  mul_req_t                mreq;
  logic                    mdone;
  logic signed [PRW-1:0]   prod;

  logic in_acc, out_free, wb_en;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign wb_en       = (state_q == ST_WAIT) && mdone;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q    <= '0;
      aw_q    <= '0;
      sw_q    <= '0;
      ratio_q <= 16'd4096;
      leak_q  <= '0;
      slope_q <= 16'd4096;
      thr_q   <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASAL_W:   bw_q    <= cfg_data_i[31:0];
        CFG_APICAL_W:  aw_q    <= cfg_data_i[31:0];
        CFG_SOMA_W:    sw_q    <= cfg_data_i[15:0];
        CFG_RATIO:     ratio_q <= cfg_data_i[15:0];
        CFG_LEAK:      leak_q  <= cfg_data_i;
        CFG_SLOPE:     slope_q <= cfg_data_i[15:0];
        CFG_THRESHOLD: thr_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    mreq.start = (state_q == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    case (step_q)
      SP_BASAL_FF: begin
        mreq.a = AW'(signed'(bw_q[31:16]));
        mreq.b = BW'(bin_q);
      end
      SP_BASAL_REC: begin
        mreq.a = AW'(signed'(bw_q[15:0]));
        mreq.b = BW'(rec_q);
      end
      SP_BASAL_LK: begin
        mreq.a = diff_q;
        mreq.b = signed'(BW'({1'b0, leak_q[47:32]}));
      end
      SP_APIC_FF: begin
        mreq.a = AW'(signed'(aw_q[31:16]));
        mreq.b = BW'(ain_q);
      end
      SP_APIC_REC: begin
        mreq.a = AW'(signed'(aw_q[15:0]));
        mreq.b = BW'(rec_q);
      end
      SP_APIC_LK: begin
        mreq.a = diff_q;
        mreq.b = signed'(BW'({1'b0, leak_q[31:16]}));
      end
      SP_SIG_ARG: begin
        mreq.a = AW'(pa_q);
        mreq.b = signed'(BW'({1'b0, slope_q}));
      end
      SP_COUPLE: begin
        // basal minus soma, coupled through the conductance ratio
        mreq.a = AW'(pb_q) - AW'(ps_q);
        mreq.b = BW'(signed'(ratio_q));
      end
      SP_DIRECT: begin
        mreq.a = AW'(signed'(sw_q));
        mreq.b = BW'(bin_q);
      end
      SP_GATE: begin
        mreq.a = diff_q;
        mreq.b = signed'(BW'({1'b0, gate_q}));
      end
      SP_SOMA_LK: begin
        mreq.a = diff_q;
        mreq.b = signed'(BW'({1'b0, leak_q[15:0]}));
      end
      default: ;
    endcase
  end

  tcn_digit_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // write-back of each product
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] tgt, arg;
  logic signed [15:0]    arg16;
  logic [15:0]           off;

  always_comb begin
    pb_d     = pb_q;
    pa_d     = pa_q;
    ps_d     = ps_q;
    spike_d  = spike_q;
    tstore_d = tstore_q;
    sum_d    = sum_q;
    diff_d   = diff_q;
    gate_d   = gate_q;
    tgt      = (sum_q + prod) >>> 8;
    arg      = prod >>> 16;
    // clamp the sigmoid argument to q4.12
    if (arg > PRW'(32767)) begin
      arg16 = 16'sh7FFF;
    end else if (arg < -PRW'(32768)) begin
      arg16 = -16'sh8000;
    end else begin
      arg16 = 16'(arg);
    end
    off = {~arg16[15], arg16[14:0]};
    case (step_q) inside
      SP_BASAL_FF, SP_APIC_FF: sum_d = prod;
      SP_BASAL_REC: diff_d = AW'(tgt - PRW'(pb_q));
      SP_APIC_REC:  diff_d = AW'(tgt - PRW'(pa_q));
      SP_BASAL_LK:  pb_d = sat_pot(PRW'(pb_q) + (prod >>> 16));
      SP_APIC_LK:   pa_d = sat_pot(PRW'(pa_q) + (prod >>> 16));
      SP_SIG_ARG:   gate_d = SIG_TABLE[off[15 -: SIG_IDX_W]];
      SP_COUPLE:    sum_d = prod >>> 12;
      SP_DIRECT:    diff_d = AW'(sat_pot(sum_q + (prod >>> 8)));
      SP_GATE:      diff_d = AW'((prod >>> 16) - PRW'(ps_q));
      SP_SOMA_LK: begin
        ps_d    = sat_pot(PRW'(ps_q) + (prod >>> 16));
        spike_d = (ps_d >= signed'(thr_q));
        if (spike_d) tstore_d = stamp_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SP_BASAL_FF;
      pb_q        <= '0;
      pa_q        <= '0;
      ps_q        <= '0;
      spike_q     <= 1'b0;
      tstore_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result takes over the output register as the old one leaves
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            step_q  <= SP_BASAL_FF;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (mdone) begin
            pb_q     <= pb_d;
            pa_q     <= pa_d;
            ps_q     <= ps_d;
            spike_q  <= spike_d;
            tstore_q <= tstore_d;
            if (step_q == SP_SOMA_LK) begin
              state_q <= ST_FINISH;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_FINISH: begin
          // hand over once the output register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bin_q   <= basal_input_i;
      ain_q   <= apical_input_i;
      rec_q   <= recurrent_input_i;
      stamp_q <= time_stamp_i;
    end
    if (wb_en) begin
      sum_q  <= sum_d;
      diff_q <= diff_d;
      gate_q <= gate_d;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_spike_q <= spike_q;
      out_time_q  <= tstore_q;
      out_soma_q  <= 32'(ps_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign spike_o           = out_spike_q;
  assign last_spike_time_o = out_time_q;
  assign soma_level_o      = out_soma_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) mdone |-> state_q == ST_WAIT)
    else $error("product finished outside the wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q != ST_IDLE |-> step_q <= SP_SOMA_LK)
    else $error("step counter ran past the last product");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(state_q) == ST_FINISH)
    else $error("result shown without a finished step");

endmodule

// ----- hw/rtl/tcn_digit_mul.sv -----
// signed multiplier, one radix-16 digit of the second operand per cycle
module tcn_digit_mul import tcn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mul_req_t              req_i,
  output logic                  done_o,
  output logic signed [PRW-1:0] prod_o
);

  localparam int unsigned ACCW = AW + BEXT;

  logic                   busy_q, first_q, done_q;
  logic [DCNT_W-1:0]      cnt_q;
  logic [BEXT-1:0]        bsh_q;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [AW-1:0]   a_q;
  logic [DIG_W-1:0]       dig;
  logic signed [DIG_W:0]  sd;
  logic signed [AW+DIG_W:0] pp;

  assign dig = bsh_q[BEXT-1 -: DIG_W];
  assign sd  = first_q ? signed'({dig[DIG_W-1], dig}) : signed'({1'b0, dig});
  assign pp  = a_q * sd;
  // msb-first horner step
  assign acc_d = (acc_q <<< DIG_W) + ACCW'(pp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= DCNT_W'(NDIG - 1);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - DCNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      bsh_q <= {{(BEXT-BW){req_i.b[BW-1]}}, req_i.b};
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      bsh_q <= bsh_q << DIG_W;
    end
  end

  assign done_o = done_q;
  assign prod_o = PRW'(acc_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("multiplier started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("multiplier done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q && cnt_q == '0 |=> done_q)
    else $error("multiplier did not finish on its last digit");

endmodule

// ----- dv/two_compartment_neuron_step_core_tb.sv -----
// self-checking testbench of the two-compartment neuron step core
module two_compartment_neuron_step_core_tb;
  import tcn_pkg::*;

  localparam int          TABLE_N    = 256;
  localparam int          IDLE_PCT   = 7;
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam int          DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] basal;
    logic signed [15:0] apical;
    logic signed [15:0] recur;
    logic [31:0]        stamp;
  } step_t;

  typedef struct packed {
    logic               spike;
    logic [31:0]        spike_time;
    logic signed [31:0] soma;
  } neuron_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] basal_input = '0;
  logic signed [15:0] apical_input = '0;
  logic signed [15:0] recurrent_input = '0;
  logic [31:0]        time_stamp = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic               spike_o;
  logic [31:0]        last_spike_time_o;
  logic signed [31:0] soma_level_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  two_compartment_neuron_step_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .basal_input_i     (basal_input),
    .apical_input_i    (apical_input),
    .recurrent_input_i (recurrent_input),
    .time_stamp_i      (time_stamp),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .spike_o           (spike_o),
    .last_spike_time_o (last_spike_time_o),
    .soma_level_o      (soma_level_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // pending time steps for the driver and predicted neuron outputs for the monitor
  step_t       step_queue[$];
  neuron_out_t neuron_out_queue[$];
  step_t       step_on_bus;

  int     steps_taken = 0;
  int     outs_seen = 0;
  int     mismatches = 0;
  longint cycle_count = 0;
  logic   sender_hold = 1'b0;
  int     rx_hold_left = 0;
  logic   rx_hold_done = 1'b0;

  // predictor copy of the register file
  logic [31:0] w_basal = '0;
  logic [31:0] w_apical = '0;
  logic signed [15:0] w_soma = '0;
  logic signed [15:0] g_ratio = 16'sd4096;
  logic [47:0] rates = '0;
  logic [15:0] slope = 16'd4096;
  logic signed [31:0] threshold = 32'sd65536;

  // predictor copy of the neuron state
  longint      v_basal = 0;
  longint      v_apical = 0;
  longint      v_soma = 0;
  logic [31:0] latched_time = '0;
  logic [15:0] gate_lut [TABLE_N];

  // no idling for a stretch in the middle of the run
  function automatic logic quiet_window();
    return (steps_taken >= 300) && (steps_taken < 420);
  endfunction

  function automatic logic take_idle();
    return !quiet_window() && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // logistic function of a q4.12 value as unsigned q0.16, exp by series up to the twelfth-order term
  function automatic logic [15:0] logistic_q16(input longint x);
    longint unsigned mag, frac, whole, ex, term, den, res;
    mag = (x < 0) ? -x : x;
    frac = mag & 64'hFFF;
    whole = mag >> 12;
    ex = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = term * frac / (longint'(k) * 4096);
      ex = (k % 2 == 1) ? ex - term : ex + term;
    end
    for (longint unsigned k = 0; k < whole; k++) ex = (ex * 64'd395007542) >> 30;
    den = (64'd1 << 30) + ex;
    res = ((64'd1 << 46) + (den >> 1)) / den;
    if (x < 0) res = 64'd65536 - res;
    return res[15:0];
  endfunction

  function automatic longint clamp_potential(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // first-order leak of a compartment toward its target, floored then saturated
  function automatic longint leak_toward(input longint p, input longint tgt,
                                         input logic [15:0] k);
    return clamp_potential(p + (((tgt - p) * longint'(k)) >>> 16));
  endfunction

  function automatic neuron_out_t advance_neuron(input step_t s);
    longint tgt_b, tgt_a, arg, idx, drive, gated;
    neuron_out_t r;
    tgt_b = (longint'($signed(w_basal[31:16])) * s.basal
             + longint'($signed(w_basal[15:0])) * s.recur) >>> 8;
    v_basal = leak_toward(v_basal, tgt_b, rates[47:32]);
    tgt_a = (longint'($signed(w_apical[31:16])) * s.apical
             + longint'($signed(w_apical[15:0])) * s.recur) >>> 8;
    v_apical = leak_toward(v_apical, tgt_a, rates[31:16]);
    arg = (v_apical * longint'(slope)) >>> 16;
    if (arg > 32767) arg = 32767;
    if (arg < -32768) arg = -32768;
    idx = ((arg + 32768) * TABLE_N) >> 16;
    if (idx >= TABLE_N) idx = TABLE_N - 1;
    drive = (((v_basal - v_soma) * longint'(g_ratio)) >>> 12)
            + ((longint'(w_soma) * s.basal) >>> 8);
    drive = clamp_potential(drive);
    gated = (drive * longint'(gate_lut[idx])) >>> 16;
    v_soma = leak_toward(v_soma, gated, rates[15:0]);
    r.spike = (v_soma >= longint'(threshold));
    if (r.spike) latched_time = s.stamp;
    r.spike_time = latched_time;
    r.soma = v_soma[31:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_q412();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic step_t rand_step();
    step_t s;
    s.basal = rand_q412();
    s.apical = rand_q412();
    s.recur = rand_q412();
    s.stamp = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
    return s;
  endfunction

  // driver: offers queued time steps, predicts each one as it is taken in
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        neuron_out_queue.push_back(advance_neuron(step_on_bus));
        steps_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (step_queue.size() > 0 && !sender_hold && !take_idle()) begin
          step_on_bus = step_queue.pop_front();
          basal_input <= step_on_bus.basal;
          apical_input <= step_on_bus.apical;
          recurrent_input <= step_on_bus.recur;
          time_stamp <= step_on_bus.stamp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction, drives the receiver's stall
  always @(posedge clk_i) begin
    neuron_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        outs_seen++;
        if (neuron_out_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: spike=%0b soma=%0d",
                                         spike_o, soma_level_o);
        end else begin
          want = neuron_out_queue.pop_front();
          if (spike_o !== want.spike || last_spike_time_o !== want.spike_time ||
              soma_level_o !== want.soma) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected spike=%0b time=%0d soma=%0d, got %0b %0d %0d",
                       outs_seen, want.spike, want.spike_time, want.soma,
                       spike_o, last_spike_time_o, soma_level_o);
          end
        end
      end
      // one long hold-off so the core fills up and pushes back on its input
      if (!rx_hold_done && outs_seen == 40) begin
        rx_hold_left = 600;
        rx_hold_done = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= take_idle();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_compartment_neuron_step_core_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASAL_W:   w_basal = value[31:0];
      CFG_APICAL_W:  w_apical = value[31:0];
      CFG_SOMA_W:    w_soma = value[15:0];
      CFG_RATIO:     g_ratio = value[15:0];
      CFG_LEAK:      rates = value;
      CFG_SLOPE:     slope = value[15:0];
      CFG_THRESHOLD: threshold = value[31:0];
      default: ;
    endcase
  endtask

  // waits until every queued step has been answered, then holds the sender so the core idles
  task automatic drain();
    while (step_queue.size() > 0 || in_valid || neuron_out_queue.size() > 0)
      @(posedge clk_i);
    sender_hold = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sender_hold = 1'b0;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) step_queue.push_back(rand_step());
  endtask

  task automatic write_all(input logic [31:0] wb, input logic [31:0] wa,
                           input logic [15:0] ws, input logic [15:0] gr,
                           input logic [47:0] lr, input logic [15:0] sl,
                           input logic [31:0] th);
    write_reg(CFG_BASAL_W, 48'(wb));
    write_reg(CFG_APICAL_W, 48'(wa));
    write_reg(CFG_SOMA_W, 48'(ws));
    write_reg(CFG_RATIO, 48'(gr));
    write_reg(CFG_LEAK, lr);
    write_reg(CFG_SLOPE, 48'(sl));
    write_reg(CFG_THRESHOLD, 48'(th));
  endtask

  initial begin
    logic [15:0] corner [4];
    for (int i = 0; i < TABLE_N; i++)
      gate_lut[i] = logistic_q16(((2 * i + 1) * 65536) / (2 * TABLE_N) - 32768);
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: zero weights and zero leak hold everything at rest
    queue_random(4);
    drain();

    // moderate settings, then corner inputs of every field
    write_all(32'h1000_0800, 32'h1000_F800, 16'h0800, 16'h1000,
              48'h4000_4000_2000, 16'h1000, 32'h0000_8000);
    for (int i = 0; i < 16; i++)
      step_queue.push_back('{corner[i % 4], corner[i / 4], corner[(i + 1) % 4],
                             (i % 2) ? 32'hFFFF_FFFF : 32'(i)});
    queue_random(230);
    drain();

    // extremes: full weights, full leak, steepest slope, lowest threshold
    write_all(32'h7FFF_7FFF, 32'h8000_8000, 16'h8000, 16'h7FFF,
              48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'h8000_0000);
    queue_random(100);
    drain();
    write_all(32'h8000_7FFF, 32'h7FFF_8000, 16'h7FFF, 16'h8000,
              48'hFFFF_0001_FFFF, 16'h0000, 32'h7FFF_FFFF);
    queue_random(60);
    drain();

    // zero leak: every compartment holds its value
    write_reg(CFG_LEAK, 48'h0);
    queue_random(20);
    drain();

    // random settings over several phases
    for (int p = 0; p < 4; p++) begin
      write_all($urandom, $urandom, 16'($urandom), 16'($urandom),
                {16'($urandom), 16'($urandom), 16'($urandom)}, 16'($urandom),
                (p % 2) ? $urandom : 32'($urandom_range(200000)));
      queue_random(45);
      drain();
    end

    if (mismatches == 0) begin
      $display("two_compartment_neuron_step_core_tb OK");
    end else begin
      $display("two_compartment_neuron_step_core_tb NOT OK");
    end
    $finish;
  end

endmodule
